// ----- sv/lzw_variable_width_encoder_defines.svh -----
// Assertion macros shared by the encoder's checker.
`ifndef LZW_VARIABLE_WIDTH_ENCODER_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LZWE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lzwe check failed");

// Next-cycle implication, disabled while reset is low.
`define LZWE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lzwe check failed");

`endif

// ----- sv/lzwe_pkg.sv -----
// Constants, types and helper functions of the LZW encoder.
`default_nettype none
package lzwe_pkg;
  localparam int MAX_CODE_BITS   = 12;
  localparam int DICT_ENTRIES    = 4096;
  localparam int HASH_ENTRIES    = 8192;
  localparam int CODE_SPACE      = (DICT_ENTRIES < (1 << MAX_CODE_BITS)) ?
                                   DICT_ENTRIES : (1 << MAX_CODE_BITS);
  localparam int LAST_CODE       = CODE_SPACE - 1;
  localparam int TOP_SYMBOL_BITS = (MAX_CODE_BITS - 1 < 9) ? MAX_CODE_BITS - 1 : 9;

  localparam int CW          = MAX_CODE_BITS;      // code width
  localparam int NW          = MAX_CODE_BITS + 1;  // free code / limit width
  localparam int SYM_W       = 9;
  localparam int WID_W       = 4;
  localparam int DICT_AW     = $clog2(CODE_SPACE);
  localparam int HASH_AW     = $clog2(HASH_ENTRIES);
  localparam int HASH_SHIFT  = 5;
  localparam int ACC_W       = 7 + 2 * MAX_CODE_BITS;
  localparam int TOT_W       = $clog2(ACC_W + 1);
  localparam int CNT_W       = $clog2(ACC_W / 8 + 2);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [3:0]    MIN_BITS_RST = 4'd8;
  localparam logic [NW-1:0] LAST_CODE_N  = NW'(LAST_CODE);

  // One request's worth of codes for the bit packer.
  typedef struct packed {
    logic [CW-1:0]    code0;
    logic [CW-1:0]    code1;
    logic [WID_W-1:0] width;
    logic [1:0]       ncodes;
    logic             flush;
  } lzwe_cmd_t;

  // Dictionary chain entry.
  typedef struct packed {
    logic [CW-1:0]    prefix;
    logic [SYM_W-1:0] symbol;
    logic [CW-1:0]    link;
  } lzwe_node_t;

  // Clamp the configured symbol width.
  function automatic logic [WID_W-1:0] eff_bits(input logic [3:0] mcb);
    logic [WID_W-1:0] b;
    b = mcb;
    if (b < WID_W'(2)) b = WID_W'(2);
    if (b > WID_W'(TOP_SYMBOL_BITS)) b = WID_W'(TOP_SYMBOL_BITS);
    return b;
  endfunction

  function automatic logic [NW-1:0] clr_code_of(input logic [WID_W-1:0] ab);
    return NW'(1) << ab;
  endfunction

  function automatic logic [SYM_W-1:0] sym_mask(input logic [SYM_W-1:0] pix,
                                                input logic [WID_W-1:0] ab);
    logic [SYM_W:0] m;
    m = ((SYM_W+1)'(1) << ab) - (SYM_W+1)'(1);
    return pix & m[SYM_W-1:0];
  endfunction

  function automatic logic [HASH_AW-1:0] hash_index(input logic [CW-1:0] prefix,
                                                    input logic [SYM_W-1:0] sym);
    logic [31:0] hraw;
    hraw = 32'(prefix) ^ (32'(sym) << HASH_SHIFT);
    return hraw[HASH_AW-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- sv/lzw_variable_width_encoder.sv -----
// GIF-style LZW encoder with growing codes of min_code_bits+1 up to 12 bits,
// packed LSB first into bytes. After reset the block sweeps the 8192-entry hash
// head memory, one entry a cycle, and stalls requests until that is done. A
// pixel request is then taken in the idle state, reads the hash head and visits
// one chain entry per walk step; a miss finishes in the state where it is found,
// so an empty bucket ends at the head read and a hit on the first chain entry in
// the first walk step. Image start and end requests finish in the idle state. Byte
// output runs in a separate packer behind a 4-entry command queue: it loads each
// request's command, then drains its bytes one a cycle unless the output stalls.
// min_code_bits is latched when an image opens.
`default_nettype none
module lzw_variable_width_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [3:0]                 cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [lzwe_pkg::SYM_W-1:0] pixel_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_run_o,
  output logic                       image_done_o
);
  import lzwe_pkg::*;

  logic      push, full, pop, empty;
  lzwe_cmd_t push_cmd, head_cmd;

  lzwe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .pixel_value_i (pixel_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fifo_full_i   (full),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  lzwe_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_cmd_o (head_cmd)
  );

  lzwe_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .image_done_o  (image_done_o)
  );
endmodule
`default_nettype wire

// ----- sv/lzwe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- sv/lzwe_fifo.sv -----
// Short command queue between the dictionary front end and the bit packer.
`default_nettype none
module lzwe_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lzwe_pkg::lzwe_cmd_t push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output lzwe_pkg::lzwe_cmd_t head_cmd_o
);
  import lzwe_pkg::*;

  lzwe_cmd_t            slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_AW:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign head_cmd_o = slot_q[rd_q];

  // Advance pointers and count.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = wr_q + QUEUE_AW'(1);
    if (pop_i)  rd_d = rd_q + QUEUE_AW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + (QUEUE_AW+1)'(1);
    if (!push_i && pop_i) cnt_d = cnt_q - (QUEUE_AW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed command.
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_cmd_i;
  end
endmodule
`default_nettype wire

// ----- sv/lzwe_front.sv -----
// Front end: accepts requests, walks the hash chains and issues code commands.
`default_nettype none
module lzwe_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [lzwe_pkg::SYM_W-1:0] pixel_value_i,
  input  logic                       cfg_we_i,
  input  logic [3:0]                 cfg_wdata_i,
  input  logic                       fifo_full_i,
  output logic                       push_o,
  output lzwe_pkg::lzwe_cmd_t        push_cmd_o
);
  import lzwe_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HEAD  = 2'd2;
  localparam logic [1:0] ST_WALK  = 2'd3;

  localparam logic [WID_W-1:0] ACT_RST = eff_bits(MIN_BITS_RST);

  logic [1:0]         state_q, state_d;
  logic [HASH_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [3:0]         min_bits_q, min_bits_d;
  logic [WID_W-1:0]   act_q, act_d;
  logic               started_q, started_d;
  logic [CW-1:0]      prefix_q, prefix_d;
  logic [NW-1:0]      nfc_q, nfc_d;
  logic [WID_W-1:0]   cw_q, cw_d;
  logic [NW-1:0]      wl_q, wl_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic [HASH_AW-1:0] hx_q, hx_d;
  logic [CW-1:0]      node_q, node_d;
  logic [CW-1:0]      hd_q, hd_d;

  logic               accept;
  logic [WID_W-1:0]   ab_new;
  logic [NW-1:0]      clr_new, clr_act, first_code;
  logic [SYM_W-1:0]   sym_in;
  logic [HASH_AW-1:0] hash_in;
  logic               do_miss;
  logic [CW-1:0]      link_sel;
  lzwe_node_t         node_rd;

  logic               head_we, head_re;
  logic [HASH_AW-1:0] head_waddr;
  logic [CW-1:0]      head_wdata, head_rdata;
  logic               chain_we, chain_re;
  logic [DICT_AW-1:0] chain_raddr;
  lzwe_node_t         chain_wdata, chain_rdata;

  // A node is live when it was assigned in the current table.
  function automatic logic live(input logic [CW-1:0] n, input logic [NW-1:0] lo,
                                input logic [NW-1:0] hi);
    return ({1'b0, n} >= lo) && ({1'b0, n} < hi);
  endfunction

  assign in_stall_o = !((state_q == ST_IDLE) && !fifo_full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign ab_new     = eff_bits(min_bits_q);
  assign clr_new    = clr_code_of(ab_new);
  assign clr_act    = clr_code_of(act_q);
  assign first_code = clr_act + NW'(2);
  assign sym_in     = sym_mask(pixel_value_i, act_q);
  assign hash_in    = hash_index(prefix_q, sym_in);
  assign node_rd    = chain_rdata;

  // Sequence lookups and table updates.
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    min_bits_d  = cfg_we_i ? cfg_wdata_i : min_bits_q;
    act_d       = act_q;
    started_d   = started_q;
    prefix_d    = prefix_q;
    nfc_d       = nfc_q;
    cw_d        = cw_q;
    wl_d        = wl_q;
    sym_d       = sym_q;
    hx_d        = hx_q;
    node_d      = node_q;
    hd_d        = hd_q;
    push_o      = 1'b0;
    push_cmd_o  = '0;
    head_we     = 1'b0;
    head_waddr  = hx_q;
    head_wdata  = nfc_q[CW-1:0];
    head_re     = 1'b0;
    chain_we    = 1'b0;
    chain_re    = 1'b0;
    chain_raddr = node_rd.link[DICT_AW-1:0];
    do_miss     = 1'b0;
    link_sel    = hd_q;

    case (state_q)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt_q;
        head_wdata = '0;
        clr_cnt_d  = clr_cnt_q + HASH_AW'(1);
        if (&clr_cnt_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i) begin
            // End of image: prefix (clear code if no image is open) and end code, then flush.
            push_o                = 1'b1;
            push_cmd_o.ncodes     = 2'd2;
            push_cmd_o.flush      = 1'b1;
            if (!started_q) begin
              act_d             = ab_new;
              cw_d              = ab_new + WID_W'(1);
              wl_d              = NW'(1) << (ab_new + WID_W'(1));
              nfc_d             = clr_new + NW'(2);
              push_cmd_o.code0  = clr_new[CW-1:0];
              push_cmd_o.code1  = CW'(clr_new + NW'(1));
              push_cmd_o.width  = ab_new + WID_W'(1);
            end else begin
              push_cmd_o.code0  = prefix_q;
              push_cmd_o.code1  = CW'(clr_act + NW'(1));
              push_cmd_o.width  = cw_q;
            end
            started_d = 1'b0;
            prefix_d  = '0;
          end else if (!started_q) begin
            // Open an image: init table and send the clear code.
            act_d             = ab_new;
            cw_d              = ab_new + WID_W'(1);
            wl_d              = NW'(1) << (ab_new + WID_W'(1));
            nfc_d             = clr_new + NW'(2);
            push_o            = 1'b1;
            push_cmd_o.code0  = clr_new[CW-1:0];
            push_cmd_o.width  = ab_new + WID_W'(1);
            push_cmd_o.ncodes = 2'd1;
            started_d         = 1'b1;
            prefix_d          = CW'(sym_mask(pixel_value_i, ab_new));
          end else begin
            // Look up the bucket head.
            sym_d   = sym_in;
            hx_d    = hash_in;
            head_re = 1'b1;
            state_d = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        hd_d     = head_rdata;
        link_sel = head_rdata;
        if (live(head_rdata, first_code, nfc_q)) begin
          chain_re    = 1'b1;
          chain_raddr = head_rdata[DICT_AW-1:0];
          node_d      = head_rdata;
          state_d     = ST_WALK;
        end else begin
          do_miss = 1'b1;
        end
      end
      ST_WALK: begin
        if (node_rd.prefix == prefix_q && node_rd.symbol == sym_q) begin
          prefix_d = node_q;
          state_d  = ST_IDLE;
        end else if (live(node_rd.link, first_code, nfc_q) && node_rd.link < node_q) begin
          chain_re    = 1'b1;
          chain_raddr = node_rd.link[DICT_AW-1:0];
          node_d      = node_rd.link;
        end else begin
          do_miss = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Miss: send prefix, add the pair while there is room, grow or restart the table.
    if (do_miss) begin
      push_o            = 1'b1;
      push_cmd_o.code0  = prefix_q;
      push_cmd_o.code1  = clr_act[CW-1:0];
      push_cmd_o.width  = cw_q;
      push_cmd_o.ncodes = 2'd1;
      if (nfc_q <= LAST_CODE_N) begin
        chain_we = 1'b1;
        head_we  = 1'b1;
        nfc_d    = nfc_q + NW'(1);
      end
      if (nfc_q == wl_q && cw_q < WID_W'(MAX_CODE_BITS)) begin
        cw_d = cw_q + WID_W'(1);
        wl_d = wl_q << 1;
      end else if (nfc_q == wl_q || nfc_q > LAST_CODE_N) begin
        push_cmd_o.ncodes = 2'd2;
        cw_d  = act_q + WID_W'(1);
        wl_d  = NW'(1) << (act_q + WID_W'(1));
        nfc_d = clr_act + NW'(2);
      end
      prefix_d = CW'(sym_q);
      state_d  = ST_IDLE;
    end

    chain_wdata.prefix = prefix_q;
    chain_wdata.symbol = sym_q;
    chain_wdata.link   = link_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      min_bits_q <= MIN_BITS_RST;
      act_q      <= ACT_RST;
      started_q  <= 1'b0;
      prefix_q   <= '0;
      nfc_q      <= clr_code_of(ACT_RST) + NW'(2);
      cw_q       <= ACT_RST + WID_W'(1);
      wl_q       <= NW'(1) << (ACT_RST + WID_W'(1));
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      min_bits_q <= min_bits_d;
      act_q      <= act_d;
      started_q  <= started_d;
      prefix_q   <= prefix_d;
      nfc_q      <= nfc_d;
      cw_q       <= cw_d;
      wl_q       <= wl_d;
    end
  end

  // Hold the working item.
  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    hx_q   <= hx_d;
    node_q <= node_d;
    hd_q   <= hd_d;
  end

  lzwe_ram #(
    .WIDTH (CW),
    .DEPTH (HASH_ENTRIES)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (hash_in),
    .rdata_o (head_rdata)
  );

  lzwe_ram #(
    .WIDTH ($bits(lzwe_node_t)),
    .DEPTH (CODE_SPACE)
  ) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    (chain_we),
    .waddr_i (nfc_q[DICT_AW-1:0]),
    .wdata_i (chain_wdata),
    .re_i    (chain_re),
    .raddr_i (chain_raddr),
    .rdata_o (chain_rdata)
  );
endmodule
`default_nettype wire

// ----- sv/lzwe_packer.sv -----
// Back end: packs codes LSB first and emits bytes through an output register.
`default_nettype none
module lzwe_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  lzwe_pkg::lzwe_cmd_t cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_run_o,
  output logic                image_done_o
);
  import lzwe_pkg::*;

  logic [ACC_W-1:0] sr_q, sr_d;
  logic [2:0]       pend_q, pend_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fl_q, fl_d;
  logic             ov_q, ov_d;
  logic [7:0]       ob_q, ob_d;
  logic             ol_q, ol_d, od_q, od_d;

  logic             out_free, n1, n2;
  logic [ACC_W-1:0] wmask, pmask, c0, c1, combined;
  logic [TOT_W-1:0] total;
  logic [CNT_W-1:0] nbytes;

  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign last_of_run_o = ol_q;
  assign image_done_o  = od_q;

  assign out_free = !ov_q || !out_stall_i;
  assign n1       = (cmd_i.ncodes != 2'd0);
  assign n2       = (cmd_i.ncodes == 2'd2);
  assign wmask    = (ACC_W'(1) << cmd_i.width) - ACC_W'(1);
  assign pmask    = (ACC_W'(1) << pend_q) - ACC_W'(1);
  assign c0       = n1 ? (ACC_W'(cmd_i.code0) & wmask) << pend_q : '0;
  assign c1       = n2 ? (ACC_W'(cmd_i.code1) & wmask) << (TOT_W'(pend_q) +
                                                         TOT_W'(cmd_i.width)) : '0;
  assign combined = (sr_q & pmask) | c0 | c1;
  assign total    = TOT_W'(pend_q) + (n1 ? TOT_W'(cmd_i.width) : '0) +
                    (n2 ? TOT_W'(cmd_i.width) : '0);
  assign nbytes   = CNT_W'(total >> 3) +
                    CNT_W'(cmd_i.flush && (total[2:0] != 3'd0));
  assign pop_o    = (cnt_q == '0) && !empty_i;

  // Load a command, then drain its bytes one a cycle while the output is not stalled.
  always_comb begin
    sr_d   = sr_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    fl_d   = fl_q;
    ov_d   = ov_q;
    ob_d   = ob_q;
    ol_d   = ol_q;
    od_d   = od_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (pop_o) begin
      sr_d   = combined;
      cnt_d  = nbytes;
      pend_d = cmd_i.flush ? 3'd0 : total[2:0];
      fl_d   = cmd_i.flush;
    end else if (cnt_q != '0 && out_free) begin
      ov_d  = 1'b1;
      ob_d  = sr_q[7:0];
      ol_d  = (cnt_q == CNT_W'(1));
      od_d  = (cnt_q == CNT_W'(1)) && fl_q;
      sr_d  = sr_q >> 8;
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
      fl_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      fl_q   <= fl_d;
      ov_q   <= ov_d;
    end
  end

  // Hold the shift register and output payload.
  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
    ob_q <= ob_d;
    ol_q <= ol_d;
    od_q <= od_d;
  end
endmodule
`default_nettype wire

// ----- sv/lzwe_checker.sv -----
// Port-level checks for the LZW encoder, bound to the top level.
`default_nettype none
`include "lzw_variable_width_encoder_defines.svh"
module lzwe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o,
  input logic       image_done_o
);
  // End of image always closes the request's run.
  `LZWE_ASSERT_IMP(a_done_is_last, clk_i, rst_ni, out_valid_o && image_done_o, last_of_run_o)
  // Hold a stalled byte.
  `LZWE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o) && $stable(last_of_run_o) && $stable(image_done_o))
  // The head memory sweep blocks requests right after reset.
  `LZWE_ASSERT_IMP(a_sweep_stall, clk_i, rst_ni, $rose(rst_ni), in_stall_o)
endmodule

bind lzw_variable_width_encoder lzwe_checker u_lzwe_checker (.*);
`default_nettype wire
